// ----- design/mtfs_pkg.sv -----
// Shared types and constants for the move-to-front search table.
// No dependencies; every other design file but mtfs_prio refers to this package by scoped names.
package mtfs_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int KEY_W       = 32;
   localparam int POS_W       = 6;
   localparam int HITS_W      = 32;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // per-cell control from the sequencer
   typedef struct packed {
      logic cmp;      // compare against the incoming key this cycle
      logic active;   // entry lies below the fill count
      logic write;    // load the pending key into this cell
      logic shift;    // take the neighbor's key (move-to-front)
   } cell_ctrl_type;

endpackage

// ----- design/mtfs_req_if.sv -----
// Request channel: load or query words into the search table.
// Depends on mtfs_pkg for the key width.
interface mtfs_req_if;
   logic                              valid;
   logic                              ready;
   logic                              mode;
   logic signed [mtfs_pkg::KEY_W-1:0] key_value;

   modport source (output valid, mode, key_value, input ready);
   modport sink   (input valid, mode, key_value, output ready);
endinterface

// ----- design/mtfs_rsp_if.sv -----
// Response channel: one result word per request word.
// Depends on mtfs_pkg for field widths.
interface mtfs_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               found;
   logic [mtfs_pkg::POS_W-1:0]         position;
   logic [mtfs_pkg::HITS_W-1:0]        hit_count;
   logic                               load_rejected;

   modport source (output valid, found, position, hit_count, load_rejected, input ready);
   modport sink   (input valid, found, position, hit_count, load_rejected, output ready);
endinterface

// ----- design/mtfs_cell.sv -----
// One table cell: holds a key, compares it, and loads or shifts from its neighbor.
// Depends on mtfs_pkg (cell_ctrl_type, KEY_W).
module mtfs_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  mtfs_pkg::cell_ctrl_type       ctrl,
   input  logic [mtfs_pkg::KEY_W-1:0]    cmp_key,
   input  logic [mtfs_pkg::KEY_W-1:0]    load_key,
   input  logic [mtfs_pkg::KEY_W-1:0]    prev_key,
   output logic [mtfs_pkg::KEY_W-1:0]    entry,
   output logic                          match
);

   logic [mtfs_pkg::KEY_W-1:0] entry_ff;
   logic                       match_ff;
   logic                       match_in;

   assign match_in = ctrl.cmp && ctrl.active && (entry_ff == cmp_key);

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   // entry payload: no reset, only cells below the fill count are ever compared
   always_ff @(posedge clock) begin
      if (ctrl.write) begin
         entry_ff <= load_key;
      end else if (ctrl.shift) begin
         entry_ff <= prev_key;
      end
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

// ----- design/mtfs_prio.sv -----
// First-hit resolution over the cells' match bits: hit flag, position, shift mask.
// Depends on nothing but its parameter.
module mtfs_prio #(
   parameter int DEPTH = 64
) (
   input  logic [DEPTH-1:0]                              match,
   output logic                                          hit,
   output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  position,
   output logic [DEPTH-1:0]                              upto_mask
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [DEPTH-1:0] first_oh;
   logic [IDX_W-1:0] pos_acc;

   // isolate lowest set bit, then mask every cell at or below it
   assign first_oh  = match & (~match + DEPTH'(1));
   assign upto_mask = first_oh | (first_oh - DEPTH'(1));
   assign hit       = |match;

   always_comb begin
      pos_acc = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (first_oh[i]) begin
            pos_acc = pos_acc | IDX_W'(i);
         end
      end
   end

   assign position = pos_acc;

endmodule

// ----- design/move_to_front_search_table_top.sv -----
// Move-to-front search table. Accepting a query word registers the key and a
// compare of it against every held cell; then, from the busy state, the table
// resolves the first hit and, on a hit, shifts the cells in front of it back by
// one and puts the key in cell 0, and writes the result word to the output
// register. A request is taken once no word is in flight and that register is
// empty or being drained in the same cycle, so not before the last result is
// written. Loads append at the fill count; cells need no clearing after reset.
// Depends on mtfs_pkg, mtfs_req_if, mtfs_rsp_if, mtfs_cell, mtfs_prio.
module move_to_front_search_table_top #(
   parameter int TABLE_DEPTH = mtfs_pkg::TABLE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   mtfs_req_if.sink    req_bus,
   mtfs_rsp_if.source  rsp_bus
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   logic                              busy_ff;
   logic                              mode_ff;
   logic [mtfs_pkg::KEY_W-1:0]        key_ff;
   logic [CNT_W-1:0]                  count_ff;
   logic [mtfs_pkg::HITS_W-1:0]       hits_ff;
   logic                              rsp_valid_ff;
   logic                              found_ff;
   logic [mtfs_pkg::POS_W-1:0]        position_ff;
   logic [mtfs_pkg::HITS_W-1:0]       hit_count_ff;
   logic                              rejected_ff;

   logic                              req_take;
   logic                              cmp_go;
   logic                              full;
   logic                              do_load;
   logic                              do_query;
   logic [mtfs_pkg::HITS_W-1:0]       hits_in;

   logic [TABLE_DEPTH-1:0]            match_vec;
   logic [TABLE_DEPTH-1:0]            upto_mask;
   logic                              hit;
   logic [IDX_W-1:0]                  hit_pos;
   logic [mtfs_pkg::KEY_W-1:0]        entries [TABLE_DEPTH];

   assign req_bus.ready = !busy_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign cmp_go        = req_take && (req_bus.mode == mtfs_pkg::MODE_QUERY);
   assign full          = (count_ff == CNT_W'(TABLE_DEPTH));
   assign do_load       = busy_ff && (mode_ff == mtfs_pkg::MODE_LOAD);
   assign do_query      = busy_ff && (mode_ff == mtfs_pkg::MODE_QUERY);
   assign hits_in       = hits_ff + mtfs_pkg::HITS_W'(do_query && hit);

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      mtfs_pkg::cell_ctrl_type    ctrl;
      logic [mtfs_pkg::KEY_W-1:0] prev_key;

      assign ctrl.cmp    = cmp_go;
      assign ctrl.active = (count_ff > CNT_W'(i));
      assign ctrl.write  = do_load && (count_ff == CNT_W'(i));
      assign ctrl.shift  = do_query && hit && upto_mask[i];

      if (i == 0) begin : g_head
         assign prev_key = key_ff;   // hit key lands at the front
      end else begin : g_body
         assign prev_key = entries[i-1];
      end

      mtfs_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .cmp_key  (req_bus.key_value),
         .load_key (key_ff),
         .prev_key (prev_key),
         .entry    (entries[i]),
         .match    (match_vec[i])
      );
   end

   mtfs_prio #(
      .DEPTH (TABLE_DEPTH)
   ) u_prio (
      .match     (match_vec),
      .hit       (hit),
      .position  (hit_pos),
      .upto_mask (upto_mask)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         hits_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            busy_ff <= 1'b0;
         end
         if (do_load && !full) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         hits_ff <= hits_in;
         if (busy_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff <= req_bus.mode;
         key_ff  <= req_bus.key_value;
      end
      if (busy_ff) begin
         found_ff     <= do_query && hit;
         position_ff  <= (do_query && hit) ? mtfs_pkg::POS_W'(hit_pos) : '0;
         hit_count_ff <= hits_in;
         rejected_ff  <= do_load && full;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.found         = found_ff;
   assign rsp_bus.position      = position_ff;
   assign rsp_bus.hit_count     = hit_count_ff;
   assign rsp_bus.load_rejected = rejected_ff;

endmodule

// ----- design/mtfs_check.sv -----
// Port-level checks for the move-to-front search table, bound to the top level.
// Depends on mtfs_pkg for field widths.
module mtfs_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_found,
   input logic [mtfs_pkg::POS_W-1:0]    rsp_position,
   input logic                          rsp_load_rejected
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped before taken");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous word in flight");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> ##1 rsp_valid)
      else $error("no response word two cycles after request");

   a_found_vs_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_found && rsp_load_rejected))
      else $error("hit and load reject in the same word");

   a_miss_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_position == '0)
      else $error("nonzero position without a hit");

endmodule

bind move_to_front_search_table_top mtfs_check u_mtfs_check (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_found         (rsp_bus.found),
   .rsp_position      (rsp_bus.position),
   .rsp_load_rejected (rsp_bus.load_rejected)
);
